[design/snc_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the nearest-center labelling block
// no dependencies

package snc_pkg;

   localparam int MAX_CLUSTERS_DEFAULT = 16;
   localparam int MAX_DIMS_DEFAULT     = 16;
   localparam int COMPONENT_BITS       = 16;
   localparam int PRODUCT_BITS         = 2 * COMPONENT_BITS;
   localparam int ACC_BITS             = 36;
   localparam int COUNT_BITS           = 5;
   localparam int USE_BITS             = 8;
   localparam int QUEUE_DEPTH          = 4;

   localparam logic [0:0] CSR_CLUSTER_COUNT   = 1'b0;
   localparam logic [0:0] CSR_DIMENSION_COUNT = 1'b1;

   localparam logic ACTION_LOAD  = 1'b0;
   localparam logic ACTION_POINT = 1'b1;

   typedef enum logic [0:0] {
      OP_LOAD  = 1'b0,
      OP_POINT = 1'b1
   } op_kind_type;

   typedef struct packed {
      logic                              action;
      logic [3:0]                        cluster_number;
      logic [3:0]                        component_number;
      logic signed [COMPONENT_BITS-1:0]  component_value;
   } req_type;

   typedef struct packed {
      logic [3:0]                        best_cluster;
      logic signed [ACC_BITS-1:0]        best_score;
   } rsp_type;

   typedef struct packed {
      op_kind_type                       kind;
      logic [3:0]                        cluster_number;
      logic [3:0]                        component_number;
      logic signed [COMPONENT_BITS-1:0]  value;
      logic                              last;
      logic [USE_BITS-1:0]               cluster_use;
   } op_type;

endpackage

[design/sphere_nearest_center_label_top.sv]
`timescale 1ns / 1ps
// Labels unit vectors (Q1.15) with the nearest of up to MAX_CLUSTERS centers by largest
// dot product. Load transactions write one center component; point transactions feed one
// component that is multiplied against every center in use in parallel lanes. The block
// takes one transaction per cycle for as long as results are taken: each cluster lane
// has its own component bank and multiply-accumulate, so a component never waits on
// another. After its final component, the result for a point passes through the bank
// read, multiply, accumulate, compare tree and result register. While a result waits on
// rsp_ready the back end holds and a four-entry queue keeps accepting until it is full.
// The center store is not cleared by reset.
// depends on snc_pkg, snc_front, snc_queue, snc_back, snc_argmax

module sphere_nearest_center_label_top import snc_pkg::*; #(
   parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEFAULT,
   parameter int MAX_DIMS     = MAX_DIMS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [0:0]            csr_index,
   input  logic [COUNT_BITS-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data
);

   logic                                  queue_full;
   logic                                  queue_empty;
   logic                                  push;
   logic                                  pop;
   op_type                                push_op;
   op_type                                head_op;
   logic                                  advance;
   logic                                  leaf_valid;
   logic [MAX_CLUSTERS-1:0]               leaf_mask;
   logic [MAX_CLUSTERS-1:0][ACC_BITS-1:0] leaf_value;

   snc_front #(
      .MAX_CLUSTERS (MAX_CLUSTERS),
      .MAX_DIMS     (MAX_DIMS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .push_op    (push_op)
   );

   snc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .pop     (pop),
      .full    (queue_full),
      .empty   (queue_empty),
      .head_op (head_op)
   );

   snc_back #(
      .MAX_CLUSTERS (MAX_CLUSTERS),
      .MAX_DIMS     (MAX_DIMS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .head_valid (!queue_empty),
      .head_op    (head_op),
      .pop        (pop),
      .leaf_valid (leaf_valid),
      .leaf_mask  (leaf_mask),
      .leaf_value (leaf_value)
   );

   snc_argmax #(
      .MAX_CLUSTERS (MAX_CLUSTERS)
   ) u_argmax (
      .clock      (clock),
      .reset      (reset),
      .leaf_valid (leaf_valid),
      .leaf_mask  (leaf_mask),
      .leaf_value (leaf_value),
      .advance    (advance),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

[design/snc_front.sv]
`timescale 1ns / 1ps
// front end: count registers, decode and filtering of incoming transactions
// depends on snc_pkg

module snc_front import snc_pkg::*; #(
   parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEFAULT,
   parameter int MAX_DIMS     = MAX_DIMS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [0:0]            csr_index,
   input  logic [COUNT_BITS-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   input  logic                  queue_full,
   output logic                  push,
   output op_type                push_op
);

   logic [COUNT_BITS-1:0] cluster_count_ff;
   logic [COUNT_BITS-1:0] dimension_count_ff;
   logic [USE_BITS-1:0]   cluster_use;
   logic [USE_BITS-1:0]   dim_use;
   logic [USE_BITS-1:0]   dnum_ext;
   logic                  load_ok;
   logic                  point_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         cluster_count_ff   <= COUNT_BITS'(1);
         dimension_count_ff <= COUNT_BITS'(1);
      end else if (csr_we) begin
         case (csr_index)
            CSR_CLUSTER_COUNT:   cluster_count_ff   <= csr_wdata;
            CSR_DIMENSION_COUNT: dimension_count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (cluster_count_ff == '0)
         cluster_use = USE_BITS'(1);
      else if (USE_BITS'(cluster_count_ff) > USE_BITS'(MAX_CLUSTERS))
         cluster_use = USE_BITS'(MAX_CLUSTERS);
      else
         cluster_use = USE_BITS'(cluster_count_ff);

      if (dimension_count_ff == '0)
         dim_use = USE_BITS'(1);
      else if (USE_BITS'(dimension_count_ff) > USE_BITS'(MAX_DIMS))
         dim_use = USE_BITS'(MAX_DIMS);
      else
         dim_use = USE_BITS'(dimension_count_ff);

      dnum_ext = USE_BITS'(req_data.component_number);
      load_ok  = (req_data.action == ACTION_LOAD)
               && (USE_BITS'(req_data.cluster_number) < USE_BITS'(MAX_CLUSTERS))
               && (dnum_ext < USE_BITS'(MAX_DIMS));
      point_ok = (req_data.action == ACTION_POINT) && (dnum_ext < dim_use);

      req_ready = !queue_full;
      push      = req_valid && !queue_full && (load_ok || point_ok);

      push_op.kind             = (req_data.action == ACTION_POINT) ? OP_POINT : OP_LOAD;
      push_op.cluster_number   = req_data.cluster_number;
      push_op.component_number = req_data.component_number;
      push_op.value            = req_data.component_value;
      push_op.last             = (dnum_ext == (dim_use - USE_BITS'(1)));
      push_op.cluster_use      = cluster_use;
   end

endmodule

[design/snc_queue.sv]
`timescale 1ns / 1ps
// small fifo of decoded operations between front and back end
// depends on snc_pkg

module snc_queue import snc_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_op,
   input  logic   pop,
   output logic   full,
   output logic   empty,
   output op_type head_op
);

   localparam int AW = $clog2(QUEUE_DEPTH);

   op_type          entry_ff [QUEUE_DEPTH];
   logic [AW-1:0]   wr_ptr_ff;
   logic [AW-1:0]   rd_ptr_ff;
   logic [AW:0]     count_ff;
   logic [AW:0]     count_in;

   assign full    = (count_ff == (AW+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head_op = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop)
         count_in = count_ff + (AW+1)'(1);
      else if (pop && !push)
         count_in = count_ff - (AW+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push)
            wr_ptr_ff <= wr_ptr_ff + AW'(1);
         if (pop)
            rd_ptr_ff <= rd_ptr_ff + AW'(1);
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         entry_ff[wr_ptr_ff] <= push_op;
   end

endmodule

[design/snc_back.sv]
`timescale 1ns / 1ps
// back end: per-center component banks, multiply lanes and saturating accumulators
// depends on snc_pkg

module snc_back import snc_pkg::*; #(
   parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEFAULT,
   parameter int MAX_DIMS     = MAX_DIMS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    advance,
   input  logic                                    head_valid,
   input  op_type                                  head_op,
   output logic                                    pop,
   output logic                                    leaf_valid,
   output logic [MAX_CLUSTERS-1:0]                 leaf_mask,
   output logic [MAX_CLUSTERS-1:0][ACC_BITS-1:0]   leaf_value
);

   localparam int CIW = $clog2(MAX_CLUSTERS);
   localparam int DIW = $clog2(MAX_DIMS);

   logic                             load_go;
   logic                             point_go;
   logic [CIW-1:0]                   bank_sel;
   logic [DIW-1:0]                   addr;

   logic                             s1_valid_ff;
   logic                             s1_last_ff;
   logic [MAX_CLUSTERS-1:0]          s1_mask_ff;
   logic signed [COMPONENT_BITS-1:0] s1_value_ff;
   logic signed [COMPONENT_BITS-1:0] rd_ff [MAX_CLUSTERS];

   logic                             s2_valid_ff;
   logic                             s2_last_ff;
   logic [MAX_CLUSTERS-1:0]          s2_mask_ff;
   logic signed [PRODUCT_BITS-1:0]   prod_ff [MAX_CLUSTERS];

   logic signed [ACC_BITS-1:0]       acc_ff [MAX_CLUSTERS];
   logic signed [ACC_BITS-1:0]       acc_in [MAX_CLUSTERS];
   logic signed [ACC_BITS-1:0]       sum_sat [MAX_CLUSTERS];

   assign pop      = advance && head_valid;
   assign load_go  = pop && (head_op.kind == OP_LOAD);
   assign point_go = pop && (head_op.kind == OP_POINT);
   assign bank_sel = CIW'(head_op.cluster_number);
   assign addr     = DIW'(head_op.component_number);

   assign leaf_valid = advance && s2_valid_ff && s2_last_ff;
   assign leaf_mask  = s2_mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= point_go;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_last_ff  <= head_op.last;
         s1_value_ff <= head_op.value;
         s2_last_ff  <= s1_last_ff;
         s2_mask_ff  <= s1_mask_ff;
      end
   end

   for (genvar k = 0; k < MAX_CLUSTERS; k++) begin : g_lane
      logic signed [COMPONENT_BITS-1:0] bank_mem [MAX_DIMS];
      logic signed [ACC_BITS:0]         wide_sum;

      always_ff @(posedge clock) begin
         if (load_go && (bank_sel == CIW'(k)))
            bank_mem[addr] <= head_op.value;
         if (advance) begin
            rd_ff[k]      <= bank_mem[addr];
            s1_mask_ff[k] <= (USE_BITS'(k) < head_op.cluster_use);
            prod_ff[k]    <= rd_ff[k] * s1_value_ff;
         end
      end

      always_comb begin
         wide_sum = (ACC_BITS+1)'(acc_ff[k]) + (ACC_BITS+1)'(prod_ff[k]);
         if (wide_sum[ACC_BITS] != wide_sum[ACC_BITS-1])
            sum_sat[k] = wide_sum[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}}
                                            : {1'b0, {(ACC_BITS-1){1'b1}}};
         else
            sum_sat[k] = wide_sum[ACC_BITS-1:0];

         acc_in[k] = acc_ff[k];
         if (s2_valid_ff) begin
            if (s2_last_ff)
               acc_in[k] = '0;
            else if (s2_mask_ff[k])
               acc_in[k] = sum_sat[k];
         end
         leaf_value[k] = s2_mask_ff[k] ? sum_sat[k] : acc_ff[k];
      end

      always_ff @(posedge clock) begin
         if (reset)
            acc_ff[k] <= '0;
         else if (advance)
            acc_ff[k] <= acc_in[k];
      end
   end

endmodule

[design/snc_argmax.sv]
`timescale 1ns / 1ps
// registered compare tree over the final dot products, plus result register
// depends on snc_pkg

module snc_argmax import snc_pkg::*; #(
   parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  leaf_valid,
   input  logic [MAX_CLUSTERS-1:0]               leaf_mask,
   input  logic [MAX_CLUSTERS-1:0][ACC_BITS-1:0] leaf_value,
   output logic                                  advance,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output rsp_type                               rsp_data
);

   localparam int LEVELS = $clog2(MAX_CLUSTERS);
   localparam int LEAVES = 1 << LEVELS;
   localparam int IW     = LEVELS;

   logic                       node_valid_ff [1:2*LEAVES-1];
   logic [IW-1:0]              node_idx_ff   [1:2*LEAVES-1];
   logic signed [ACC_BITS-1:0] node_val_ff   [1:2*LEAVES-1];
   logic [LEVELS:0]            stage_valid_ff;
   logic                       rsp_valid_ff;
   rsp_type                    rsp_data_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else if (advance) begin
         stage_valid_ff <= {leaf_valid, stage_valid_ff[LEVELS:1]};
         rsp_valid_ff   <= stage_valid_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff.best_cluster <= 4'(node_idx_ff[1]);
         rsp_data_ff.best_score   <= node_val_ff[1];
      end
   end

   for (genvar k = 0; k < LEAVES; k++) begin : g_leaf
      if (k < MAX_CLUSTERS) begin : g_used
         always_ff @(posedge clock) begin
            if (advance) begin
               node_valid_ff[LEAVES+k] <= leaf_mask[k];
               node_idx_ff[LEAVES+k]   <= IW'(k);
               node_val_ff[LEAVES+k]   <= leaf_value[k];
            end
         end
      end else begin : g_pad
         always_ff @(posedge clock) begin
            node_valid_ff[LEAVES+k] <= 1'b0;
            node_idx_ff[LEAVES+k]   <= IW'(k);
            node_val_ff[LEAVES+k]   <= '0;
         end
      end
   end

   // lower index wins a tie
   for (genvar i = 1; i < LEAVES; i++) begin : g_node
      logic pick_right;

      assign pick_right = node_valid_ff[2*i+1]
                        && (!node_valid_ff[2*i]
                            || (node_val_ff[2*i+1] > node_val_ff[2*i]));

      always_ff @(posedge clock) begin
         if (advance) begin
            node_valid_ff[i] <= node_valid_ff[2*i] || node_valid_ff[2*i+1];
            node_idx_ff[i]   <= pick_right ? node_idx_ff[2*i+1] : node_idx_ff[2*i];
            node_val_ff[i]   <= pick_right ? node_val_ff[2*i+1] : node_val_ff[2*i];
         end
      end
   end

endmodule

[tb/sv/sphere_nearest_center_label_checker.sv]
`timescale 1ns / 1ps
// transaction checker for the nearest-centre labelling block: tracks centre store,
// count registers and dot sums, and compares every label taken off the result channel
// depends on snc_pkg

module sphere_nearest_center_label_checker import snc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [0:0]            csr_index,
   input  logic [COUNT_BITS-1:0] csr_wdata,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_type               rsp_data,
   output int                    mismatch_count,
   output int                    labels_outstanding
);

   localparam int     NUM_CENTRES = MAX_CLUSTERS_DEFAULT;
   localparam int     NUM_DIMS    = MAX_DIMS_DEFAULT;
   localparam longint SCORE_MAX   = (longint'(1) <<< (ACC_BITS - 1)) - 1;
   localparam longint SCORE_MIN   = -SCORE_MAX - 1;

   logic signed [COMPONENT_BITS-1:0] centre_bank [NUM_CENTRES][NUM_DIMS];
   logic signed [ACC_BITS-1:0]       dot_sum [NUM_CENTRES];
   logic [COUNT_BITS-1:0]            cluster_setting;
   logic [COUNT_BITS-1:0]            dimension_setting;
   rsp_type                          expected_labels [$];

   initial begin
      mismatch_count     = 0;
      labels_outstanding = 0;
   end

   function automatic int in_use(input logic [COUNT_BITS-1:0] raw, input int limit);
      if (raw == 0) return 1;
      return (int'(raw) > limit) ? limit : int'(raw);
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 50) begin
         $display("mismatch at %0t ns: %s", $realtime, msg);
      end
   endtask

   task automatic take_component(input req_type item);
      int                               clusters;
      int                               dims;
      int                               dim;
      int                               best;
      int                               k;
      longint                           sum;
      logic signed [COMPONENT_BITS-1:0] value;
      logic signed [ACC_BITS-1:0]       best_score;
      rsp_type                          label;
      clusters = in_use(cluster_setting, NUM_CENTRES);
      dims     = in_use(dimension_setting, NUM_DIMS);
      dim      = int'(item.component_number);
      value    = item.component_value;
      if (item.action == ACTION_LOAD) begin
         centre_bank[item.cluster_number][dim] = value;
      end else if (dim < dims) begin
         for (k = 0; k < clusters; k++) begin
            sum = longint'(dot_sum[k]) + longint'(value) * longint'(centre_bank[k][dim]);
            if (sum > SCORE_MAX) sum = SCORE_MAX;
            if (sum < SCORE_MIN) sum = SCORE_MIN;
            dot_sum[k] = sum[ACC_BITS-1:0];
         end
         // final component: pick the largest sum, lowest index on ties
         if (dim == dims - 1) begin
            best       = 0;
            best_score = dot_sum[0];
            for (k = 1; k < clusters; k++) begin
               if (dot_sum[k] > best_score) begin
                  best       = k;
                  best_score = dot_sum[k];
               end
            end
            label.best_cluster = best[3:0];
            label.best_score   = best_score;
            expected_labels.push_back(label);
            for (k = 0; k < NUM_CENTRES; k++) dot_sum[k] = '0;
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cluster_setting   = COUNT_BITS'(1);
         dimension_setting = COUNT_BITS'(1);
         for (int k = 0; k < NUM_CENTRES; k++) dot_sum[k] = '0;
         expected_labels.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_CLUSTER_COUNT) cluster_setting = csr_wdata;
            else if (csr_index == CSR_DIMENSION_COUNT) dimension_setting = csr_wdata;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_labels.size() == 0) begin
               report_mismatch($sformatf("label %0d score %0d with none expected",
                  rsp_data.best_cluster, rsp_data.best_score));
            end else begin
               want = expected_labels.pop_front();
               if (rsp_data.best_cluster !== want.best_cluster) begin
                  report_mismatch($sformatf("best_cluster %0d, expected %0d",
                     rsp_data.best_cluster, want.best_cluster));
               end
               if (rsp_data.best_score !== want.best_score) begin
                  report_mismatch($sformatf("best_score %0d, expected %0d",
                     rsp_data.best_score, want.best_score));
               end
            end
         end
         if (req_valid && req_ready) take_component(req_data);
      end
      labels_outstanding = expected_labels.size();
   end

endmodule

[tb/sv/sphere_nearest_center_label_top_tb.sv]
`timescale 1ns / 1ps
// testbench top for the nearest-centre labelling block: clock, reset, register writes,
// load and point transactions with random gaps and stalls, and the final verdict
// depends on snc_pkg, sphere_nearest_center_label_top, sphere_nearest_center_label_checker

module sphere_nearest_center_label_top_tb;
   import snc_pkg::*;

   localparam int CYCLE_LIMIT = 400_000;
   localparam int NUM_DIMS    = MAX_DIMS_DEFAULT;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  csr_we    = 1'b0;
   logic [0:0]            csr_index = CSR_CLUSTER_COUNT;
   logic [COUNT_BITS-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;

   int   mismatch_count;
   int   labels_outstanding;
   int   cycle_count = 0;
   int   dims_in_use = 1;
   int   sent = 0;
   logic calm = 1'b0;

   sphere_nearest_center_label_top u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   sphere_nearest_center_label_checker u_label_checker (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data           (req_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_data           (rsp_data),
      .mismatch_count     (mismatch_count),
      .labels_outstanding (labels_outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 32);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic logic signed [COMPONENT_BITS-1:0] pick_component();
      case ($urandom_range(7))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return '0;
         3: return $urandom_range(1) ? 16'sd1 : -16'sd1;
         default: return COMPONENT_BITS'($urandom);
      endcase
   endfunction

   task automatic send(input req_type item);
      if (!calm) begin
         while ($urandom_range(99) < 32) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_load(input int centre, input int dim,
                            input logic signed [COMPONENT_BITS-1:0] value);
      req_type item;
      item.action           = ACTION_LOAD;
      item.cluster_number   = centre[3:0];
      item.component_number = dim[3:0];
      item.component_value  = value;
      send(item);
   endtask

   task automatic send_point(input int dim, input logic signed [COMPONENT_BITS-1:0] value);
      req_type item;
      item.action           = ACTION_POINT;
      item.cluster_number   = 4'($urandom_range(15));
      item.component_number = dim[3:0];
      item.component_value  = value;
      send(item);
   endtask

   // hold the input idle until every label is out and the pipeline is empty
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (labels_outstanding != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic configure(input int clusters, input int dims);
      drain();
      csr_we    <= 1'b1;
      csr_index <= CSR_CLUSTER_COUNT;
      csr_wdata <= clusters[COUNT_BITS-1:0];
      @(posedge clock);
      csr_index <= CSR_DIMENSION_COUNT;
      csr_wdata <= dims[COUNT_BITS-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      dims_in_use = (dims == 0) ? 1 : ((dims > NUM_DIMS) ? NUM_DIMS : dims);
   endtask

   initial begin
      int                               phase;
      int                               phase_end;
      int                               d;
      int                               n;
      logic signed [COMPONENT_BITS-1:0] v;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // one centre, one component: extreme products
      send_load(0, 0, 16'sh7fff);
      send_point(0, 16'sh7fff);
      send_point(0, 16'sh8000);
      send_load(0, 0, 16'sh8000);
      send_point(0, 16'sh8000);
      send_load(15, 15, 16'sh7fff);
      send_point(15, 16'sd1);

      // three centres, two components: ties, repeats, ignored components
      configure(3, 2);
      send_load(0, 1, 16'sd0);
      send_load(1, 0, 16'sd200);
      send_load(1, 1, -16'sd5);
      send_load(2, 0, 16'sd200);
      send_load(2, 1, -16'sd5);
      send_point(0, 16'sd1);
      send_point(1, 16'sd0);
      send_point(0, 16'sd1);
      send_point(0, 16'sd1);
      send_point(1, 16'sd0);
      send_point(1, 16'sd0);
      send_point(1, 16'sh7fff);
      send_point(9, 16'sd3);

      // fill the whole centre store so no unwritten entry is ever read
      for (int c = 0; c < MAX_CLUSTERS_DEFAULT; c++) begin
         for (int k = 0; k < NUM_DIMS; k++) send_load(c, k, pick_component());
      end

      for (phase = 0; phase < 10; phase++) begin
         case (phase)
            0: configure(16, 16);
            1: configure(0, 0);
            2: configure(31, 31);
            3: configure(17, 1);
            4: configure(1, 16);
            5: configure(2, 3);
            default: configure($urandom_range(31), $urandom_range(31));
         endcase
         calm = (phase == 6);
         phase_end = sent + 150;
         while (sent < phase_end) begin
            n = $urandom_range(99);
            if (n < 70) begin
               for (d = 0; d < dims_in_use; d++) begin
                  if ($urandom_range(19) == 0) begin
                     send_load($urandom_range(15), $urandom_range(15), pick_component());
                     sent++;
                  end
                  send_point(d, pick_component());
                  sent++;
               end
            end else if (n < 78) begin
               // long run on one component to drive the sums into saturation
               v = $urandom_range(1) ? 16'sh8000 : 16'sh7fff;
               if ($urandom_range(1)) begin
                  send_load(0, 0, $urandom_range(1) ? 16'sh8000 : 16'sh7fff);
                  sent++;
               end
               n = $urandom_range(32, 40);
               repeat (n) send_point(0, v);
               send_point(dims_in_use - 1, v);
               sent += n + 1;
            end else if (n < 88) begin
               send_load($urandom_range(15), $urandom_range(15), pick_component());
               sent++;
            end else if (n < 94) begin
               if (dims_in_use < NUM_DIMS) begin
                  send_point($urandom_range(NUM_DIMS - 1, dims_in_use),
                             COMPONENT_BITS'($urandom));
               end else begin
                  send_load($urandom_range(15), $urandom_range(15), pick_component());
                  sent++;
               end
            end else begin
               send_point($urandom_range(15), pick_component());
               sent++;
            end
         end
      end

      calm = 1'b0;
      drain();
      if (mismatch_count == 0 && labels_outstanding == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[sphere_nearest_center_label_top.f]
design/snc_pkg.sv
design/snc_front.sv
design/snc_queue.sv
design/snc_back.sv
design/snc_argmax.sv
design/sphere_nearest_center_label_top.sv
tb/sv/sphere_nearest_center_label_checker.sv
tb/sv/sphere_nearest_center_label_top_tb.sv
